[rtl/pcac_pkg.sv]
// ---------------------------------------------------------------------------
// PIN-code alarm controller package
// Item types, event and mode codes and sizing constants shared by the
// controller's modules.
// ---------------------------------------------------------------------------
package pcac_pkg;

   // Number of keys in a code.
   localparam int CODE_LEN = 4;
   // Count of keys taken so far; must be able to hold CODE_LEN itself.
   localparam int CNT_W    = $clog2(CODE_LEN + 1);

   // Event codes on req_type.
   localparam logic [1:0] REQ_KEY    = 2'd0;
   localparam logic [1:0] REQ_MOTION = 2'd1;
   localparam logic [1:0] REQ_TIMER  = 2'd2;

   // Highest valid key (hash).
   localparam logic [3:0] KEY_MAX = 4'd11;

   // Modes.
   localparam logic [1:0] MODE_SETUP  = 2'd0;
   localparam logic [1:0] MODE_ARMING = 2'd1;
   localparam logic [1:0] MODE_ARMED  = 2'd2;

   // Verdicts.
   localparam logic [1:0] VERDICT_NONE = 2'd0;
   localparam logic [1:0] VERDICT_BAD  = 2'd1;
   localparam logic [1:0] VERDICT_GOOD = 2'd2;

   typedef logic [3:0] key_type;
   typedef key_type [CODE_LEN-1:0] code_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] key_code;
      logic       motion_level;
   } req_item_type;

   typedef struct packed {
      logic       key_echo_valid;
      logic [3:0] key_echo;
      logic [1:0] pin_verdict;
      logic       motion_reported;
      logic       arm_reported;
      logic       buzzer_on;
      logic [1:0] mode;
   } rsp_item_type;

endpackage

[rtl/pcac_core.sv]
// ---------------------------------------------------------------------------
// PIN-code alarm controller core
// Holds the alarm state and computes one result per event. The result is
// combinational from the current state and the event; the state moves on
// when fire is high.
// ---------------------------------------------------------------------------
module pcac_core
   import pcac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [1:0]     mode_ff, mode_in;
   code_type       stored_code_ff, stored_code_in;
   code_type       entered_code_ff, entered_code_in;
   logic [CNT_W-1:0] stored_count_ff, stored_count_in;
   logic [CNT_W-1:0] entered_count_ff, entered_count_in;
   logic           timer_running_ff, timer_running_in;
   logic           first_period_seen_ff, first_period_seen_in;
   logic           buzzer_ff, buzzer_in;
   logic           codes_match;

   always_comb begin
      mode_in              = mode_ff;
      stored_code_in       = stored_code_ff;
      entered_code_in      = entered_code_ff;
      stored_count_in      = stored_count_ff;
      entered_count_in     = entered_count_ff;
      timer_running_in     = timer_running_ff;
      first_period_seen_in = first_period_seen_ff;
      buzzer_in            = buzzer_ff;
      codes_match          = 1'b1;
      result               = '0;

      case (item.req_type)
         REQ_KEY: begin
            if (item.key_code <= KEY_MAX) begin
               result.key_echo_valid = 1'b1;
               result.key_echo       = item.key_code;
               if (mode_ff == MODE_SETUP) begin
                  if (stored_count_ff < CNT_W'(CODE_LEN)) begin
                     for (int i = 0; i < CODE_LEN; i++) begin
                        if (stored_count_ff == CNT_W'(i)) begin
                           stored_code_in[i] = item.key_code;
                        end
                     end
                     stored_count_in = stored_count_ff + 1'b1;
                  end
                  if (stored_count_in >= CNT_W'(CODE_LEN)) begin
                     timer_running_in = 1'b1;
                     mode_in          = MODE_ARMING;
                  end
               end else begin
                  if (entered_count_ff < CNT_W'(CODE_LEN)) begin
                     for (int i = 0; i < CODE_LEN; i++) begin
                        if (entered_count_ff == CNT_W'(i)) begin
                           entered_code_in[i] = item.key_code;
                        end
                     end
                     entered_count_in = entered_count_ff + 1'b1;
                  end
                  // The compare sees the entry including the key just taken.
                  for (int i = 0; i < CODE_LEN; i++) begin
                     if (stored_code_ff[i] != entered_code_in[i]) begin
                        codes_match = 1'b0;
                     end
                  end
                  if (entered_count_in >= CNT_W'(CODE_LEN)) begin
                     entered_code_in  = '0;
                     entered_count_in = '0;
                     if (codes_match) begin
                        mode_in              = MODE_SETUP;
                        stored_code_in       = '0;
                        stored_count_in      = '0;
                        timer_running_in     = 1'b0;
                        first_period_seen_in = 1'b0;
                        buzzer_in            = 1'b0;
                        result.pin_verdict   = VERDICT_GOOD;
                     end else begin
                        result.pin_verdict   = VERDICT_BAD;
                     end
                  end
               end
            end
         end
         REQ_MOTION: begin
            result.motion_reported = 1'b1;
            if (mode_ff == MODE_ARMED) begin
               buzzer_in = 1'b1;
            end
         end
         REQ_TIMER: begin
            if (timer_running_ff) begin
               if (!first_period_seen_ff) begin
                  first_period_seen_in = 1'b1;
               end else begin
                  result.arm_reported  = 1'b1;
                  if (item.motion_level) begin
                     buzzer_in = 1'b1;
                  end
                  first_period_seen_in = 1'b0;
                  mode_in              = MODE_ARMED;
                  timer_running_in     = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      result.buzzer_on = buzzer_in;
      result.mode      = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff              <= MODE_SETUP;
         stored_code_ff       <= '0;
         entered_code_ff      <= '0;
         stored_count_ff      <= '0;
         entered_count_ff     <= '0;
         timer_running_ff     <= 1'b0;
         first_period_seen_ff <= 1'b0;
         buzzer_ff            <= 1'b0;
      end else if (fire) begin
         mode_ff              <= mode_in;
         stored_code_ff       <= stored_code_in;
         entered_code_ff      <= entered_code_in;
         stored_count_ff      <= stored_count_in;
         entered_count_ff     <= entered_count_in;
         timer_running_ff     <= timer_running_in;
         first_period_seen_ff <= first_period_seen_in;
         buzzer_ff            <= buzzer_in;
      end
   end

endmodule

[rtl/pin_code_alarm_controller_top.sv]
// ---------------------------------------------------------------------------
// PIN-code alarm controller
// Keypad code lock with exit delay, motion alarm and buzzer control.
// ---------------------------------------------------------------------------
// The controller takes one event per cycle while req_stall is low (key,
// motion edge or exit timer period) and returns exactly one result item for
// each. An event is held in an input register, evaluated against the alarm
// state in a single pass and written to a result register, which drives rsp.
// A stall on the result side holds the result register;
// the input register still takes one more event, and only then does
// req_stall rise. After reset the block is in setup mode and ready at once.
module pin_code_alarm_controller_top
   import pcac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type core_result;
   logic         advance;
   logic         req_take;

   // The held event moves on once the result register is free or emptying.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   pcac_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[rtl/pcac_checker.sv]
// ---------------------------------------------------------------------------
// PIN-code alarm controller checker
// Port-level properties of the controller, bound to the top level.
// ---------------------------------------------------------------------------
module pcac_checker
   import pcac_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   // A stalled result stays and does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // A good code always returns the block to setup with the buzzer off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.pin_verdict == VERDICT_GOOD
         |-> rsp_item.mode == MODE_SETUP && !rsp_item.buzzer_on)
      else $error("good code did not clear the alarm");

   // The end of the exit delay always leaves the alarm armed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.arm_reported |-> rsp_item.mode == MODE_ARMED)
      else $error("arm reported outside armed mode");

   // Only a key produces an echo or a verdict, and one event reports one kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.key_echo_valid
         |-> rsp_item.key_echo == 4'd0 && rsp_item.pin_verdict == VERDICT_NONE)
      else $error("verdict or echo without a key");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.motion_reported
         |-> !rsp_item.key_echo_valid && !rsp_item.arm_reported)
      else $error("motion reported together with another event");

endmodule

bind pin_code_alarm_controller_top pcac_checker u_pcac_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
